// ----- design/olid_pkg.sv -----
// Shared types, sizes and codes for the ordered list block.
package olid_pkg;

	localparam int DEPTH     = 16;
	localparam int IDX_W     = $clog2(DEPTH);
	localparam int CNT_W     = $clog2(DEPTH + 1);
	localparam int IN_IDX_W  = 5;
	localparam int LEN_W     = 5;
	localparam int WORD_W    = 32;
	localparam int CMP_W     = (CNT_W > IN_IDX_W) ? CNT_W : IN_IDX_W;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [IDX_W-1:0]         pos_t;
	typedef logic [CNT_W-1:0]         cnt_t;
	typedef logic [CMP_W-1:0]         cmp_t;

	typedef enum logic [2:0] {
		ACT_APPEND  = 3'd0,
		ACT_INSERT  = 3'd1,
		ACT_DELETE  = 3'd2,
		ACT_REPLACE = 3'd3,
		ACT_READ    = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// Datapath operations; append is an insert at the current length
	typedef enum logic [1:0] {
		DP_NOP    = 2'd0,
		DP_INSERT = 2'd1,
		DP_DELETE = 2'd2,
		DP_WRITE  = 2'd3
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		pos_t   pos;
		word_t  value;
	} dp_cmd_t;

	typedef struct packed {
		cnt_t  count;
		word_t rd_data;
	} dp_stat_t;

endpackage

// ----- design/olid_dp.sv -----
// Datapath: row of shifting entry cells, length counter and read mux.
module olid_dp (
	input  logic             clk,
	input  logic             arst_n,
	input  olid_pkg::dp_cmd_t cmd,
	input  olid_pkg::pos_t   rd_pos,
	output olid_pkg::dp_stat_t stat
);

	olid_pkg::word_t entries_q [olid_pkg::DEPTH];
	olid_pkg::cnt_t  count_q;

	// Each cell loads the new word, takes its lower neighbor or its upper neighbor, or holds its value
	for (genvar k = 0; k < olid_pkg::DEPTH; k++) begin : g_cell
		always_ff @(posedge clk) begin
			case (cmd.op)
				olid_pkg::DP_INSERT: begin
					if (olid_pkg::IDX_W'(k) == cmd.pos) begin
						entries_q[k] <= cmd.value;
					end else if (olid_pkg::IDX_W'(k) > cmd.pos) begin
						if (k > 0) begin
							entries_q[k] <= entries_q[(k > 0) ? k - 1 : 0];
						end
					end
				end
				olid_pkg::DP_DELETE: begin
					if (olid_pkg::IDX_W'(k) >= cmd.pos) begin
						if (k < olid_pkg::DEPTH - 1) begin
							entries_q[k] <= entries_q[(k < olid_pkg::DEPTH - 1) ? k + 1 : k];
						end
					end
				end
				olid_pkg::DP_WRITE: begin
					if (olid_pkg::IDX_W'(k) == cmd.pos) begin
						entries_q[k] <= cmd.value;
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else begin
			case (cmd.op)
				olid_pkg::DP_INSERT: count_q <= count_q + olid_pkg::CNT_W'(1);
				olid_pkg::DP_DELETE: count_q <= count_q - olid_pkg::CNT_W'(1);
				default:             count_q <= count_q;
			endcase
		end
	end

	assign stat.count   = count_q;
	assign stat.rd_data = entries_q[rd_pos];

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= olid_pkg::CNT_W'(olid_pkg::DEPTH))
		else $error("length exceeds depth");

	a_insert_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == olid_pkg::DP_INSERT |->
			count_q < olid_pkg::CNT_W'(olid_pkg::DEPTH) &&
			olid_pkg::CNT_W'(cmd.pos) <= count_q)
		else $error("insert issued into full list or past the end");

	a_delete_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == olid_pkg::DP_DELETE || cmd.op == olid_pkg::DP_WRITE) |->
			olid_pkg::CNT_W'(cmd.pos) < count_q)
		else $error("delete or write issued at a position beyond the length");

	a_insert_count: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.op == olid_pkg::DP_INSERT |=>
			count_q == $past(count_q) + olid_pkg::CNT_W'(1))
		else $error("length did not advance after insert");

endmodule

// ----- design/olid_ctrl.sv -----
// Controller: request decode, error checks and the result register.
module olid_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [4:0]         index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         length,
	output logic signed [31:0] read_value,
	output logic [1:0]         status,
	output olid_pkg::dp_cmd_t  cmd,
	output olid_pkg::pos_t     rd_pos,
	input  olid_pkg::dp_stat_t stat
);

	typedef enum logic {
		S_EMPTY,
		S_HELD
	} state_t;

	state_t              state_q;
	logic [4:0]          length_q;
	olid_pkg::word_t     read_value_q;
	olid_pkg::status_t   status_q;

	logic                accept;
	olid_pkg::cmp_t      idx_ext;
	olid_pkg::cmp_t      cnt_ext;
	olid_pkg::cmp_t      new_ext;
	olid_pkg::pos_t      idx_pos;
	olid_pkg::pos_t      cnt_pos;
	logic                full;
	olid_pkg::dp_op_t    op;
	olid_pkg::pos_t      op_pos;
	olid_pkg::status_t   st;
	olid_pkg::word_t     rd;
	olid_pkg::cnt_t      new_cnt;

	assign in_stall = (state_q == S_HELD) && out_stall;
	assign accept   = in_valid && !in_stall;

	assign idx_ext = olid_pkg::CMP_W'(index);
	assign cnt_ext = olid_pkg::CMP_W'(stat.count);
	assign idx_pos = idx_ext[olid_pkg::IDX_W-1:0];
	assign cnt_pos = cnt_ext[olid_pkg::IDX_W-1:0];
	assign full    = stat.count == olid_pkg::CNT_W'(olid_pkg::DEPTH);
	assign rd_pos  = idx_pos;

	always_comb begin
		op      = olid_pkg::DP_NOP;
		op_pos  = idx_pos;
		st      = olid_pkg::ST_DONE;
		rd      = '0;
		new_cnt = stat.count;
		case (action)
			olid_pkg::ACT_APPEND: begin
				if (full) begin
					st = olid_pkg::ST_FULL;
				end else begin
					op      = olid_pkg::DP_INSERT;
					op_pos  = cnt_pos;
					new_cnt = stat.count + olid_pkg::CNT_W'(1);
				end
			end
			olid_pkg::ACT_INSERT: begin
				if (full) begin
					st = olid_pkg::ST_FULL;
				end else if (idx_ext > cnt_ext) begin
					st = olid_pkg::ST_RANGE;
				end else begin
					op      = olid_pkg::DP_INSERT;
					new_cnt = stat.count + olid_pkg::CNT_W'(1);
				end
			end
			olid_pkg::ACT_DELETE: begin
				if (idx_ext >= cnt_ext) begin
					st = olid_pkg::ST_RANGE;
				end else begin
					op      = olid_pkg::DP_DELETE;
					new_cnt = stat.count - olid_pkg::CNT_W'(1);
				end
			end
			olid_pkg::ACT_REPLACE: begin
				if (idx_ext >= cnt_ext) begin
					st = olid_pkg::ST_RANGE;
				end else begin
					op = olid_pkg::DP_WRITE;
				end
			end
			olid_pkg::ACT_READ: begin
				if (idx_ext >= cnt_ext) begin
					st = olid_pkg::ST_RANGE;
				end else begin
					rd = stat.rd_data;
				end
			end
			default: begin
			end
		endcase
	end

	assign new_ext   = olid_pkg::CMP_W'(new_cnt);
	assign cmd.op    = accept ? op : olid_pkg::DP_NOP;
	assign cmd.pos   = op_pos;
	assign cmd.value = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_EMPTY;
			length_q     <= '0;
			read_value_q <= '0;
			status_q     <= olid_pkg::ST_DONE;
		end else begin
			case (state_q)
				S_EMPTY, S_HELD: begin
					if (accept) begin
						state_q      <= S_HELD;
						length_q     <= new_ext[olid_pkg::LEN_W-1:0];
						read_value_q <= rd;
						status_q     <= st;
					end else if (!out_stall) begin
						state_q <= S_EMPTY;
					end
				end
				default: state_q <= S_EMPTY;
			endcase
		end
	end

	assign out_valid  = state_q == S_HELD;
	assign length     = length_q;
	assign read_value = read_value_q;
	assign status     = status_q;

	a_err_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status_q != olid_pkg::ST_DONE |-> read_value_q == '0)
		else $error("failed request carries read data");

	a_err_no_op: assert property (@(posedge clk) disable iff (!arst_n)
		accept && st != olid_pkg::ST_DONE |-> cmd.op == olid_pkg::DP_NOP)
		else $error("failed request changed the list");

	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid && length_q == $past(new_ext[olid_pkg::LEN_W-1:0]))
		else $error("accepted request produced no result");

endmodule

// ----- design/ordered_list_insert_delete_top.sv -----
// Top level of the ordered list block: controller plus entry datapath.
//
// Ordered list of up to olid_pkg::DEPTH signed 32-bit words with a length count.
// Input channel (in_valid / in_stall) carries one request: action, index, value.
//   append, insert at index (later entries move up), delete at index (later
//   entries move down), replace at index, read at index; other codes do nothing.
// Output channel (out_valid / out_stall) carries one result per request:
//   length after the request, read_value (zero unless a read succeeded) and
//   status: done, list full (append or insert), or index out of range.
// A failed request leaves the list untouched.
// Latency: the result appears on the cycle after the request is accepted.
// Throughput: one request per cycle unless in_stall is raised; every entry cell
//   shifts or loads in the same cycle, so insert and delete take no longer than a read.
// The result register decouples the two sides: a new request is taken whenever
//   no result is waiting or the waiting one is taken in the same cycle. While
//   the receiver stalls a held result, in_stall is raised and the result holds.
// Reset (arst_n low) empties the list and drops any pending result; stored
//   words are not cleared and are never returned before they are written.
module ordered_list_insert_delete_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         action,
	input  logic [4:0]         index,
	input  logic signed [31:0] value,
	output logic               out_valid,
	input  logic               out_stall,
	output logic [4:0]         length,
	output logic signed [31:0] read_value,
	output logic [1:0]         status
);

	// Command from the controller to the cells, length and read word back
	olid_pkg::dp_cmd_t  cmd;
	olid_pkg::dp_stat_t stat;
	olid_pkg::pos_t     rd_pos;

	olid_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.length     (length),
		.read_value (read_value),
		.status     (status),
		.cmd        (cmd),
		.rd_pos     (rd_pos),
		.stat       (stat)
	);

	olid_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.rd_pos (rd_pos),
		.stat   (stat)
	);

endmodule

// ----- verif/ordered_list_insert_delete_top_tb.sv -----
// Self-checking testbench for the ordered list block: directed table, then biased random traffic.
module ordered_list_insert_delete_top_tb;
	timeunit 1ns;
	timeprecision 1ps;

	// Action codes the block treats as no operation
	localparam logic [2:0] ACT_SPARE_LO = 3'd5;
	localparam logic [2:0] ACT_SPARE_HI = 3'd7;

	localparam int RESET_CYCLES  = 11;
	localparam int SEGMENTS      = 8;
	localparam int SEGMENT_ITEMS = 210;
	localparam int HOLD_OFF_LEN  = 150;
	localparam int DRAIN_CYCLES  = 8;
	localparam int MAX_REPORTS   = 60;

	// One result as the block should present it
	typedef struct packed {
		logic [olid_pkg::LEN_W-1:0] len;
		olid_pkg::word_t            rd;
		olid_pkg::status_t          st;
	} list_result_t;

	// One line of the directed table; reps > 1 repeats it with the value stepped by one
	typedef struct packed {
		logic [2:0]                 act;
		logic [4:0]                 idx;
		olid_pkg::word_t            val;
		logic [4:0]                 reps;
		logic                       typed;
		logic [olid_pkg::LEN_W-1:0] len;
		olid_pkg::word_t            rd;
		olid_pkg::status_t          st;
	} dir_row_t;

	// Traffic mixes: grow pushes toward full, shrink toward empty
	typedef enum {MIX_GROW, MIX_SHRINK, MIX_EVEN} mix_t;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_stall;
	logic [2:0]         action;
	logic [4:0]         index;
	logic signed [31:0] value;
	logic               out_valid;
	logic               out_stall;
	logic [4:0]         length;
	logic signed [31:0] read_value;
	logic [1:0]         status;

	// Predictor state: our own copy of the list
	olid_pkg::word_t list_words [olid_pkg::DEPTH];
	int unsigned     list_len;

	// Results the block owes us, oldest first
	list_result_t pending_results [$];
	list_result_t head_result;

	// Idle percentages per request / per cycle and the receiver hold-off length
	int tx_idle_pct;
	int rx_idle_pct;
	int hold_off_cycles;

	int fail_count;
	int report_count;
	int requests_sent;
	int results_checked;
	int full_seen;
	int range_seen;
	int peak_len;
	int in_stall_cycles;

	// Directed table: typed expectations only where they are obvious
	dir_row_t directed_rows [26] = '{
		// empty list: every positional access is out of range
		'{olid_pkg::ACT_READ,     5'd0,  32'h0000_0000, 5'd1,  1'b1,
			5'd0,  32'h0000_0000, olid_pkg::ST_RANGE},
		'{olid_pkg::ACT_DELETE,   5'd0,  32'h0000_0000, 5'd1,  1'b1,
			5'd0,  32'h0000_0000, olid_pkg::ST_RANGE},
		'{olid_pkg::ACT_REPLACE,  5'd0,  32'h1111_1111, 5'd1,  1'b1,
			5'd0,  32'h0000_0000, olid_pkg::ST_RANGE},
		'{olid_pkg::ACT_INSERT,   5'd1,  32'h2222_2222, 5'd1,  1'b1,
			5'd0,  32'h0000_0000, olid_pkg::ST_RANGE},
		// value extremes, append ignores the index
		'{olid_pkg::ACT_INSERT,   5'd0,  32'h7FFF_FFFF, 5'd1,  1'b1,
			5'd1,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_APPEND,   5'd31, 32'h8000_0000, 5'd1,  1'b1,
			5'd2,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_READ,     5'd1,  32'h0000_0000, 5'd1,  1'b1,
			5'd2,  32'h8000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_READ,     5'd0,  32'hFFFF_FFFF, 5'd1,  1'b1,
			5'd2,  32'h7FFF_FFFF, olid_pkg::ST_DONE},
		// insert at the current length behaves as an append
		'{olid_pkg::ACT_INSERT,   5'd2,  32'hFFFF_FFFF, 5'd1,  1'b1,
			5'd3,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_INSERT,   5'd1,  32'h1234_5678, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_REPLACE,  5'd3,  32'h0000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		// unused action codes do nothing
		'{ACT_SPARE_LO,           5'd31, 32'hFFFF_FFFF, 5'd1,  1'b1,
			5'd4,  32'h0000_0000, olid_pkg::ST_DONE},
		'{ACT_SPARE_HI,           5'd0,  32'h0000_0000, 5'd1,  1'b1,
			5'd4,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_REPLACE,  5'd4,  32'h5A5A_5A5A, 5'd1,  1'b1,
			5'd4,  32'h0000_0000, olid_pkg::ST_RANGE},
		// delete the last, then the first entry
		'{olid_pkg::ACT_DELETE,   5'd3,  32'h0000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_DELETE,   5'd0,  32'h0000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_READ,     5'd31, 32'h0000_0000, 5'd1,  1'b1,
			5'd2,  32'h0000_0000, olid_pkg::ST_RANGE},
		// fill to the brim
		'{olid_pkg::ACT_APPEND,   5'd0,  32'h0F0F_0000, 5'd14, 1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_APPEND,   5'd0,  32'h5555_5555, 5'd1,  1'b1,
			5'd16, 32'h0000_0000, olid_pkg::ST_FULL},
		'{olid_pkg::ACT_INSERT,   5'd3,  32'h6666_6666, 5'd1,  1'b1,
			5'd16, 32'h0000_0000, olid_pkg::ST_FULL},
		// full takes precedence over a bad index
		'{olid_pkg::ACT_INSERT,   5'd31, 32'h7777_7777, 5'd1,  1'b1,
			5'd16, 32'h0000_0000, olid_pkg::ST_FULL},
		'{olid_pkg::ACT_READ,     5'd15, 32'h0000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_DELETE,   5'd15, 32'h0000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_INSERT,   5'd15, 32'h0BAD_CAFE, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_REPLACE,  5'd15, 32'h8000_0000, 5'd1,  1'b0,
			5'd0,  32'h0000_0000, olid_pkg::ST_DONE},
		'{olid_pkg::ACT_READ,     5'd16, 32'h0000_0000, 5'd1,  1'b1,
			5'd16, 32'h0000_0000, olid_pkg::ST_RANGE}
	};

	// Per-segment idling and mix; the last segment runs with no idling at all
	int   tx_pct_plan [SEGMENTS] = '{30, 10, 50, 0, 20, 40, 15, 0};
	int   rx_pct_plan [SEGMENTS] = '{30, 50, 10, 20, 0, 40, 25, 0};
	mix_t mix_plan    [SEGMENTS] = '{MIX_GROW, MIX_SHRINK, MIX_EVEN, MIX_GROW,
		MIX_SHRINK, MIX_EVEN, MIX_GROW, MIX_EVEN};

	ordered_list_insert_delete_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.action     (action),
		.index      (index),
		.value      (value),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.length     (length),
		.read_value (read_value),
		.status     (status)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Apply one request to the local list and return what the block must answer
	function automatic list_result_t apply_list_request(logic [2:0] act, logic [4:0] idx,
		olid_pkg::word_t val);
		list_result_t res;
		res.rd = '0;
		res.st = olid_pkg::ST_DONE;
		case (act)
			olid_pkg::ACT_APPEND: begin
				if (list_len >= olid_pkg::DEPTH) begin
					res.st = olid_pkg::ST_FULL;
				end else begin
					list_words[list_len] = val;
					list_len++;
				end
			end
			olid_pkg::ACT_INSERT: begin
				// full is checked before the position
				if (list_len >= olid_pkg::DEPTH) begin
					res.st = olid_pkg::ST_FULL;
				end else if (idx > list_len) begin
					res.st = olid_pkg::ST_RANGE;
				end else begin
					for (int j = list_len; j > idx; j--)
						list_words[j] = list_words[j-1];
					list_words[idx] = val;
					list_len++;
				end
			end
			olid_pkg::ACT_DELETE: begin
				if (idx >= list_len) begin
					res.st = olid_pkg::ST_RANGE;
				end else begin
					for (int j = idx; j + 1 < list_len; j++)
						list_words[j] = list_words[j+1];
					list_len--;
				end
			end
			olid_pkg::ACT_REPLACE: begin
				if (idx >= list_len)
					res.st = olid_pkg::ST_RANGE;
				else
					list_words[idx] = val;
			end
			olid_pkg::ACT_READ: begin
				if (idx >= list_len)
					res.st = olid_pkg::ST_RANGE;
				else
					res.rd = list_words[idx];
			end
			default: ;
		endcase
		res.len = list_len[olid_pkg::LEN_W-1:0];
		return res;
	endfunction

	// Offer one request at a falling edge, hold it until taken, then book its result
	task automatic send_request(input logic [2:0] act, input logic [4:0] idx,
		input olid_pkg::word_t val, input bit typed, input list_result_t typed_res);
		list_result_t res;
		@(negedge clk);
		if (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(negedge clk);
		end
		in_valid <= 1'b1;
		action   <= act;
		index    <= idx;
		value    <= val;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		// accepted at this edge: advance the local list
		res = apply_list_request(act, idx, val);
		if (res.st == olid_pkg::ST_FULL)
			full_seen++;
		if (res.st == olid_pkg::ST_RANGE)
			range_seen++;
		if (list_len > peak_len)
			peak_len = list_len;
		pending_results.push_back(typed ? typed_res : res);
		requests_sent++;
	endtask

	// Draw a random request; most positions are legal so the list moves through all fill levels
	task automatic pick_request(input mix_t mix, output logic [2:0] act, output logic [4:0] idx,
		output olid_pkg::word_t val);
		int r;
		r = $urandom_range(0, 99);
		if (r < 4) begin
			act = 3'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
		end else begin
			r = $urandom_range(0, 99);
			case (mix)
				MIX_GROW: act = (r < 35) ? olid_pkg::ACT_APPEND :
					(r < 65) ? olid_pkg::ACT_INSERT :
					(r < 75) ? olid_pkg::ACT_DELETE :
					(r < 85) ? olid_pkg::ACT_REPLACE : olid_pkg::ACT_READ;
				MIX_SHRINK: act = (r < 10) ? olid_pkg::ACT_APPEND :
					(r < 20) ? olid_pkg::ACT_INSERT :
					(r < 60) ? olid_pkg::ACT_DELETE :
					(r < 75) ? olid_pkg::ACT_REPLACE : olid_pkg::ACT_READ;
				default: act = (r < 20) ? olid_pkg::ACT_APPEND :
					(r < 40) ? olid_pkg::ACT_INSERT :
					(r < 60) ? olid_pkg::ACT_DELETE :
					(r < 80) ? olid_pkg::ACT_REPLACE : olid_pkg::ACT_READ;
			endcase
		end
		// a slice of wild positions keeps the range checks busy
		if ($urandom_range(0, 99) < 15 || act == olid_pkg::ACT_APPEND || act >= ACT_SPARE_LO)
			idx = 5'($urandom_range(0, 31));
		else if (act == olid_pkg::ACT_INSERT)
			idx = 5'($urandom_range(0, list_len));
		else if (list_len == 0)
			idx = 5'($urandom_range(0, 31));
		else
			idx = 5'($urandom_range(0, list_len - 1));
		case ($urandom_range(0, 15))
			0: val = 32'h7FFF_FFFF;
			1: val = 32'h8000_0000;
			2: val = '0;
			3: val = '1;
			default: val = $urandom;
		endcase
	endtask

	task automatic note_mismatch(input string field, input logic [31:0] expd,
		input logic [31:0] got);
		fail_count++;
		report_count++;
		if (report_count <= MAX_REPORTS)
			$display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, expd, got);
	endtask

	// Result checker: compare every taken result with the oldest booked one
	always @(posedge clk) begin
		if (arst_n && in_valid && in_stall)
			in_stall_cycles++;
		if (arst_n && out_valid && !out_stall) begin
			results_checked++;
			if (pending_results.size() == 0) begin
				fail_count++;
				report_count++;
				if (report_count <= MAX_REPORTS)
					$display("%0t ns: unexpected result, expected none, got len %0d rd %0h st %0d",
						$time, length, read_value, status);
			end else begin
				head_result = pending_results.pop_front();
				if (length !== head_result.len)
					note_mismatch("length", 32'(head_result.len), 32'(length));
				if (read_value !== head_result.rd)
					note_mismatch("read_value", head_result.rd, read_value);
				if (status !== head_result.st)
					note_mismatch("status", 32'(head_result.st), 32'(status));
			end
		end
	end

	// Receiver: random stall bursts, plus one long hold-off on request
	initial begin
		out_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_cycles > 0) begin
				// hold long enough that the result register fills and the input stalls
				out_stall <= 1'b1;
				repeat (hold_off_cycles) @(negedge clk);
				hold_off_cycles = 0;
				out_stall <= 1'b0;
			end else if (rx_idle_pct != 0 && $urandom_range(0, 99) < rx_idle_pct / 4) begin
				out_stall <= 1'b1;
				repeat ($urandom_range(1, 12)) @(negedge clk);
				out_stall <= 1'b0;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	// Watchdog: a correct run ends far sooner
	initial begin
		#3_000_000;
		$display("%0t ns: timeout, %0d results still owed", $time, pending_results.size());
		$display("Some tests failed");
		$finish;
	end

	initial begin : main_seq
		dir_row_t        row;
		list_result_t    typed_res;
		logic [2:0]      act;
		logic [4:0]      idx;
		olid_pkg::word_t val;

		arst_n          = 1'b0;
		in_valid        = 1'b0;
		action          = '0;
		index           = '0;
		value           = '0;
		list_len        = 0;
		tx_idle_pct     = 20;
		rx_idle_pct     = 20;
		hold_off_cycles = 0;
		fail_count      = 0;
		report_count    = 0;
		requests_sent   = 0;
		results_checked = 0;
		full_seen       = 0;
		range_seen      = 0;
		peak_len        = 0;
		in_stall_cycles = 0;
		for (int k = 0; k < olid_pkg::DEPTH; k++)
			list_words[k] = '0;

		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed part: walk the table, stepping values on repeated rows
		foreach (directed_rows[n]) begin
			row = directed_rows[n];
			typed_res.len = row.len;
			typed_res.rd  = row.rd;
			typed_res.st  = row.st;
			for (int r = 0; r < row.reps; r++)
				send_request(row.act, row.idx, row.val + r, row.typed, typed_res);
		end

		// Random part: segments with their own mix and idling
		for (int s = 0; s < SEGMENTS; s++) begin
			tx_idle_pct = tx_pct_plan[s];
			rx_idle_pct = rx_pct_plan[s];
			for (int i = 0; i < SEGMENT_ITEMS; i++) begin
				// long receiver hold-off while we keep offering requests
				if (s == 3 && i == 5)
					hold_off_cycles = HOLD_OFF_LEN;
				pick_request(mix_plan[s], act, idx, val);
				send_request(act, idx, val, 1'b0, typed_res);
			end
		end

		@(negedge clk);
		in_valid <= 1'b0;

		// Drain: everything booked must come back, then keep watching for strays
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Covered %0d requests (%0d results checked), %0d list-full and %0d out-of-range",
			requests_sent, results_checked, full_seen, range_seen);
		$display("Peak length %0d, %0d cycles with the input held off, %0d failures",
			peak_len, in_stall_cycles, fail_count);
		if (fail_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
